### design/pmb_pkg.sv
// Shared constants, register codes and types for the particle motion step.
package pmb_pkg;

   localparam int HALF_SCALE_DEF      = 16;
   localparam int MIN_HARD_RADIUS_DEF = 32;
   localparam int POS_BITS_DEF        = 24;

   // Radii stay below 512 over the whole parameter range.
   localparam int RAD_BITS = 9;

   localparam int SIZE_FACTOR = 52;
   localparam int FULL_HARD   = 255;

   // Reciprocal of 255 scaled by 2**23, exact for products up to 32640.
   localparam int RECIP_255   = 32897;
   localparam int RECIP_SHIFT = 23;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_MAX_POSITION  = 2'd0,
      REG_WALL_HARDNESS = 2'd1,
      REG_GLOBAL_SIZE   = 2'd2,
      REG_MODE_FLAGS    = 2'd3
   } csr_index_type;

   localparam int MODE_WRAP     = 0;
   localparam int MODE_BOUNCE   = 1;
   localparam int MODE_KILL     = 2;
   localparam int MODE_GRAVITY  = 3;
   localparam int MODE_AGE_HUE  = 4;
   localparam int MODE_OWN_SIZE = 5;

   typedef struct packed {
      logic [RAD_BITS-1:0] hard;
      logic [RAD_BITS-1:0] rrad;
   } radius_type;

endpackage

### design/pmb_if.sv
// Request and response channel interfaces of the particle motion step.
interface pmb_req_if #(parameter int POS_BITS = 24);
   logic                valid;
   logic                ready;
   logic [POS_BITS-1:0] pos;
   logic [7:0]          vel;
   logic [15:0]         life;
   logic [7:0]          hue;
   logic                perpetual;
   logic                pinned;
   logic                reverse_gravity;
   logic                was_out;
   logic [7:0]          own_size;
   logic                has_own_size;

   modport source (output valid, pos, vel, life, hue, perpetual, pinned, reverse_gravity,
                   was_out, own_size, has_own_size, input ready);
   modport sink   (input valid, pos, vel, life, hue, perpetual, pinned, reverse_gravity,
                   was_out, own_size, has_own_size, output ready);
endinterface

interface pmb_rsp_if #(parameter int POS_BITS = 24);
   logic                valid;
   logic                ready;
   logic [POS_BITS-1:0] new_pos;
   logic [7:0]          new_vel;
   logic [15:0]         new_life;
   logic [7:0]          new_hue;
   logic                out_of_bounds;

   modport source (output valid, new_pos, new_vel, new_life, new_hue, out_of_bounds,
                   input ready);
   modport sink   (input valid, new_pos, new_vel, new_life, new_hue, out_of_bounds,
                   output ready);
endinterface

### design/pmb_radius.sv
// Hard and render radius selection from the particle or the global size.
module pmb_radius #(
   parameter int HALF_SCALE      = pmb_pkg::HALF_SCALE_DEF,
   parameter int MIN_HARD_RADIUS = pmb_pkg::MIN_HARD_RADIUS_DEF
) (
   input  logic                 per_size,
   input  logic                 has_own_size,
   input  logic [7:0]           own_size,
   input  logic [7:0]           global_size,
   output pmb_pkg::radius_type  radius
);
   import pmb_pkg::*;

   localparam logic [RAD_BITS-1:0] MIN_R  = RAD_BITS'(MIN_HARD_RADIUS);
   localparam logic [RAD_BITS-1:0] HALF_R = RAD_BITS'(MIN_HARD_RADIUS / 2);
   localparam logic [RAD_BITS-1:0] REND_R = RAD_BITS'(HALF_SCALE - 1);

   logic             use_own;
   logic [7:0]       size;
   logic [13:0]      scaled;

   assign use_own = per_size && has_own_size;
   assign size    = use_own ? own_size : global_size;
   assign scaled  = 14'(size) * 14'(SIZE_FACTOR);

   always_comb begin
      radius.rrad = REND_R + RAD_BITS'(size);
      if (size > 8'd1) begin
         radius.hard = MIN_R + RAD_BITS'(scaled[13:6]);
      end else if (size == 8'd1 && !use_own) begin
         radius.hard = MIN_R;
      end else begin
         radius.hard = HALF_R;
      end
   end
endmodule

### design/particle_motion_bounds_step.sv
// Top level of the pipelined one-dimensional particle motion step.
//
// One particle request enters per clock unless a stalled response has backed the pipeline
// up to its first stage; its response leaves from the last stage register. The depth is
// set by the wrap remainder, which the pipeline works out four dividend bits per stage against
// max_position + 1. Every stage holds its own valid bit, so a stalled response only
// backs up the stages behind it and bubbles are squeezed out. Configuration is written
// through csr_we/csr_index/csr_wdata and must only change while no request is in flight.
module particle_motion_bounds_step #(
   parameter int HALF_SCALE      = pmb_pkg::HALF_SCALE_DEF,
   parameter int MIN_HARD_RADIUS = pmb_pkg::MIN_HARD_RADIUS_DEF,
   parameter int POS_BITS        = pmb_pkg::POS_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   pmb_req_if.sink                            req_chan,
   pmb_rsp_if.source                          rsp_chan,
   input  logic                               csr_we,
   input  logic [pmb_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [pmb_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import pmb_pkg::*;

   // Position arithmetic width, and one more bit for comparisons against wall limits.
   localparam int W    = POS_BITS + 1;
   localparam int CW   = W + 1;
   localparam int BPS  = 4;
   localparam int NDIG = (POS_BITS + BPS - 1) / BPS;
   localparam int MAGW = NDIG * BPS;
   localparam int NST  = 4 + NDIG;
   localparam int MOD0 = 3;

   typedef struct packed {
      logic [POS_BITS-1:0] pos;
      logic [7:0]          vel;
      logic [15:0]         life;
      logic [7:0]          hue;
      logic                dead;
      logic                pinned;
      logic                revgrav;
      logic                was_out;
      logic [RAD_BITS-1:0] hard;
      logic [RAD_BITS-1:0] rrad;
      logic signed [W-1:0] np;
      logic                bounced;
      logic                vneg;
      logic [15:0]         vmag;
      logic                outr;
      logic [MAGW-1:0]     mag;
      logic [16:0]         rem;
      logic                oob;
   } item_type;

   // Configuration registers.
   logic [15:0] max_position_ff;
   logic [7:0]  wall_hardness_ff;
   logic [7:0]  global_size_ff;
   logic [5:0]  mode_flags_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_position_ff  <= 16'd1023;
         wall_hardness_ff <= 8'd255;
         global_size_ff   <= 8'd0;
         mode_flags_ff    <= 6'd0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_MAX_POSITION:  max_position_ff  <= csr_wdata;
            REG_WALL_HARDNESS: wall_hardness_ff <= csr_wdata[7:0];
            REG_GLOBAL_SIZE:   global_size_ff   <= csr_wdata[7:0];
            REG_MODE_FLAGS:    mode_flags_ff    <= csr_wdata[5:0];
         endcase
      end
   end

   // Shared views of the configuration in comparison widths.
   logic signed [CW-1:0] maxp_s;
   logic [16:0]          divisor;
   logic [17:0]          divisor_w;

   assign maxp_s    = $signed({{(CW-16){1'b0}}, max_position_ff});
   assign divisor   = {1'b0, max_position_ff} + 17'd1;
   assign divisor_w = {1'b0, divisor};

   // Pipeline stages with per-stage valid and ready.
   item_type         stage_ff [NST];
   item_type         stage_in [NST];
   logic [NST-1:0]   valid_ff;
   logic [NST:0]     ready_w;

   assign ready_w[NST] = rsp_chan.ready;
   for (genvar k = 0; k < NST; k++) begin : g_ready
      assign ready_w[k] = !valid_ff[k] || ready_w[k+1];
   end
   assign req_chan.ready = ready_w[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (ready_w[0]) begin
            valid_ff[0] <= req_chan.valid;
         end
         for (int k = 1; k < NST; k++) begin
            if (ready_w[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NST; k++) begin
         if (ready_w[k]) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   // Stage 0: lifetime, hue, radii and the raw step pos + vel.
   radius_type radius;
   logic [15:0] life_dec;

   pmb_radius #(
      .HALF_SCALE      (HALF_SCALE),
      .MIN_HARD_RADIUS (MIN_HARD_RADIUS)
   ) u_radius (
      .per_size     (mode_flags_ff[MODE_OWN_SIZE]),
      .has_own_size (req_chan.has_own_size),
      .own_size     (req_chan.own_size),
      .global_size  (global_size_ff),
      .radius       (radius)
   );

   assign life_dec = req_chan.perpetual ? req_chan.life : req_chan.life - 16'd1;

   always_comb begin
      stage_in[0]         = '0;
      stage_in[0].pos     = req_chan.pos;
      stage_in[0].vel     = req_chan.vel;
      stage_in[0].dead    = (req_chan.life == 16'd0);
      stage_in[0].pinned  = req_chan.pinned;
      stage_in[0].revgrav = req_chan.reverse_gravity;
      stage_in[0].was_out = req_chan.was_out;
      stage_in[0].hard    = radius.hard;
      stage_in[0].rrad    = radius.rrad;
      stage_in[0].np      = $signed({req_chan.pos[POS_BITS-1], req_chan.pos})
                          + $signed({{(W-8){req_chan.vel[7]}}, req_chan.vel});
      stage_in[0].hue     = req_chan.hue;
      if (req_chan.life == 16'd0) begin
         stage_in[0].life = 16'd0;
      end else begin
         stage_in[0].life = life_dec;
         if (mode_flags_ff[MODE_AGE_HUE]) begin
            stage_in[0].hue = (life_dec > 16'd255) ? 8'hFF : life_dec[7:0];
         end
      end
   end

   // Stage 1: wall bounce decision, position clamp and the velocity product.
   logic signed [CW-1:0] b_np;
   logic signed [CW-1:0] b_hard;
   logic signed [CW-1:0] b_top;
   logic                 b_low;
   logic                 b_high;
   logic                 b_doit;
   logic [7:0]           b_vn;
   logic [7:0]           b_mag;

   assign b_np   = {stage_ff[0].np[W-1], stage_ff[0].np};
   assign b_hard = $signed({{(CW-RAD_BITS){1'b0}}, stage_ff[0].hard});
   assign b_top  = maxp_s - b_hard;
   assign b_low  = b_np < b_hard;
   assign b_high = b_np > b_top;
   // Under gravity only the floor on the pull side is skipped.
   assign b_doit = mode_flags_ff[MODE_BOUNCE] && !stage_ff[0].dead && (b_low || b_high)
                && !(mode_flags_ff[MODE_GRAVITY]
                     && (stage_ff[0].revgrav ? b_low : (b_np > b_hard)));
   // Negation wraps in eight bits, so the most negative speed stays negative.
   assign b_vn   = ~stage_ff[0].vel + 8'd1;
   assign b_mag  = b_vn[7] ? (~b_vn + 8'd1) : b_vn;

   always_comb begin
      stage_in[1] = stage_ff[0];
      stage_in[1].bounced = b_doit;
      stage_in[1].vneg    = b_vn[7];
      stage_in[1].vmag    = 16'(b_mag) * 16'(wall_hardness_ff);
      if (b_doit) begin
         stage_in[1].np = b_low ? b_hard[W-1:0] : b_top[W-1:0];
      end
   end

   // Stage 2: divide the product by 255, then set up the wrap remainder.
   logic [31:0]          c_prod;
   logic [7:0]           c_q;
   logic signed [CW-1:0] c_np;
   logic [W-1:0]         c_abs;

   assign c_prod = 32'(stage_ff[1].vmag) * 32'(RECIP_255);
   assign c_q    = c_prod[RECIP_SHIFT +: 8];
   assign c_np   = {stage_ff[1].np[W-1], stage_ff[1].np};
   assign c_abs  = stage_ff[1].np[W-1] ? (~stage_ff[1].np + W'(1)) : stage_ff[1].np;

   always_comb begin
      stage_in[2] = stage_ff[1];
      if (stage_ff[1].bounced) begin
         stage_in[2].vel = stage_ff[1].vneg ? (~c_q + 8'd1) : c_q;
      end
      stage_in[2].outr = (c_np < 0) || (c_np > maxp_s);
      stage_in[2].mag  = MAGW'(c_abs[POS_BITS-1:0]);
      stage_in[2].rem  = 17'd0;
   end

   // Remainder stages: restoring steps on |np|, four dividend bits per stage.
   for (genvar k = MOD0; k < MOD0 + NDIG; k++) begin : g_mod
      logic [17:0]     r_w;
      logic [MAGW-1:0] m_w;
      always_comb begin
         r_w = {1'b0, stage_ff[k-1].rem};
         m_w = stage_ff[k-1].mag;
         for (int j = 0; j < BPS; j++) begin
            r_w = {r_w[16:0], m_w[MAGW-1]};
            m_w = {m_w[MAGW-2:0], 1'b0};
            if (r_w >= divisor_w) begin
               r_w = r_w - divisor_w;
            end
         end
         stage_in[k]     = stage_ff[k-1];
         stage_in[k].rem = r_w[16:0];
         stage_in[k].mag = m_w;
      end
   end

   // Final stage: wrap or bounds check, kill, pinning and saturation.
   localparam int LAST = NST - 1;

   item_type             f_x;
   logic [16:0]          f_wrap;
   logic signed [CW-1:0] f_np;
   logic signed [CW-1:0] f_rrad;
   logic signed [CW-1:0] f_far;
   logic signed [CW-1:0] f_res;
   logic                 f_oob;
   logic                 f_kill;

   localparam logic signed [CW-1:0] PMAX = CW'((64'sd1 <<< (POS_BITS - 1)) - 1);
   localparam logic signed [CW-1:0] PMIN = -PMAX - CW'(1);

   assign f_x    = stage_ff[LAST-1];
   assign f_np   = {f_x.np[W-1], f_x.np};
   assign f_rrad = $signed({{(CW-RAD_BITS){1'b0}}, f_x.rrad});
   assign f_far  = maxp_s <<< 2;
   // C-style remainder takes the dividend's sign, then is lifted into range.
   assign f_wrap = !f_x.np[W-1] ? f_x.rem : ((f_x.rem == 17'd0) ? 17'd0 : divisor - f_x.rem);
   assign f_oob  = f_x.outr && !mode_flags_ff[MODE_WRAP]
                && ((f_np < -f_rrad) || (f_np > maxp_s + f_rrad));
   assign f_kill = mode_flags_ff[MODE_KILL]
                && !(mode_flags_ff[MODE_GRAVITY]
                     && (f_x.revgrav ? ((f_np < 0) || (f_np > f_far))
                                     : ((f_np > 0) && (f_np < f_far))));

   always_comb begin
      stage_in[LAST] = f_x;
      f_res = f_np;
      if (f_x.dead) begin
         stage_in[LAST].oob = f_x.was_out;
         f_res = $signed({{(CW-POS_BITS){f_x.pos[POS_BITS-1]}}, f_x.pos});
      end else begin
         stage_in[LAST].oob = f_oob;
         if (f_x.outr && mode_flags_ff[MODE_WRAP]) begin
            f_res = $signed({{(CW-17){1'b0}}, f_wrap});
         end
         if (f_oob && f_kill) begin
            stage_in[LAST].life = 16'd0;
         end
         if (f_x.pinned) begin
            f_res = $signed({{(CW-POS_BITS){f_x.pos[POS_BITS-1]}}, f_x.pos});
            stage_in[LAST].vel = 8'd0;
         end
         if (f_res > PMAX) begin
            f_res = PMAX;
         end else if (f_res < PMIN) begin
            f_res = PMIN;
         end
      end
      stage_in[LAST].np = f_res[W-1:0];
   end

   // The last stage register is the response register.
   assign rsp_chan.valid         = valid_ff[LAST];
   assign rsp_chan.new_pos       = stage_ff[LAST].np[POS_BITS-1:0];
   assign rsp_chan.new_vel       = stage_ff[LAST].vel;
   assign rsp_chan.new_life      = stage_ff[LAST].life;
   assign rsp_chan.new_hue       = stage_ff[LAST].hue;
   assign rsp_chan.out_of_bounds = stage_ff[LAST].oob;

   a_reset_empty : assert property (@(posedge clock) reset |=> valid_ff == '0)
      else $error("pipeline not empty after reset");

   a_accept_loads : assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> valid_ff[0])
      else $error("accepted request missing from the first stage");

   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      valid_ff[LAST] && !rsp_chan.ready |=> valid_ff[LAST] && $stable(stage_ff[LAST]))
      else $error("stalled response changed or was lost");
endmodule
